/* hdl/trimmed_mean_window_filter_core_assert.svh */
// assertion macros used by the filter core
`ifndef TRIMMED_MEAN_WINDOW_FILTER_CORE_ASSERT_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define TMWF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define TMWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tmwf_pkg.sv */
package tmwf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CHAN_W   = 3;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CHAN_W-1:0]   chan_t;

    // status of the rank and accumulate unit
    typedef struct packed {
        logic busy;
        logic done;
    } acc_stat_t;

endpackage

/* hdl/tmwf_row_mem.sv */
module tmwf_row_mem #(
    parameter int ROWS  = 8,
    parameter int ROW_W = 72,
    parameter int AW    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [ROW_W-1:0] wr_data,
    output logic [ROW_W-1:0] rd_data
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROWS-1:0]  row_valid_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // storage and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a row never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hdl/tmwf_rank_acc.sv */
module tmwf_rank_acc #(
    parameter int WINDOW_DEPTH = 6,
    parameter int TRIM         = 2,
    parameter int SUM_W        = 15
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [WINDOW_DEPTH*tmwf_pkg::SAMPLE_W-1:0] window,
    output logic [SUM_W-1:0]                          sum,
    output tmwf_pkg::acc_stat_t                       stat
);

    import tmwf_pkg::*;

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int RW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [RW-1:0] RANK_LO = RW'(TRIM);
    localparam logic [RW-1:0] RANK_HI = RW'(WINDOW_DEPTH - TRIM);
    localparam logic [IW-1:0] IDX_LAST = IW'(WINDOW_DEPTH - 1);

    sample_t          win_reg [WINDOW_DEPTH];
    logic [IW-1:0]    idx_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             busy_reg;
    logic             done_reg;

    sample_t          cur;
    logic [RW-1:0]    rank;
    logic             keep;

    // stable rank of the current element against the whole window
    always_comb
    begin
        cur  = win_reg[idx_reg];
        rank = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++)
        begin
            if ((win_reg[j] < cur) || ((win_reg[j] == cur) && (IW'(j) < idx_reg)))
            begin
                rank = rank + RW'(1);
            end
        end
        keep = (rank >= RANK_LO) && (rank < RANK_HI);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int s = 0; s < WINDOW_DEPTH; s++)
            begin
                win_reg[s] <= window[s*SAMPLE_W +: SAMPLE_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            sum_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                idx_reg  <= '0;
                sum_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (keep)
                begin
                    sum_reg <= sum_reg + SUM_W'(cur);
                end
                if (idx_reg == IDX_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
        end
    end

    assign sum       = sum_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hdl/trimmed_mean_window_filter_core.sv */
// multi-channel trimmed-mean filter: each item is one sample with its channel number,
// written into that channel's window at the shared slot position; the window is then
// ranked, the lowest and highest TRIM_COUNT values are dropped (lowered to
// (WINDOW_DEPTH-1)/2 per side when the trim would leave nothing) and the floored mean of
// the rest comes out with the channel number. the slot advances after each sample of the
// last channel. windows read as zero after reset through per-row valid bits, so no clearing
// pass is needed. an item in range goes through one row read, one merge and write-back, one
// ranking step per window entry in the shared rank unit, then the reciprocal multiply and
// output load, which waits while the output register is held; the next item is taken only
// when it is done. a channel number at or above CHANNELS goes straight to output load with
// a zero result and leaves the windows alone. the result sits in an output register, so the
// next item is taken while it waits to be collected
module trimmed_mean_window_filter_core #(
    parameter int CHANNELS     = 8,
    parameter int WINDOW_DEPTH = 6,
    parameter int TRIM_COUNT   = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tmwf_pkg::chan_t   channel,
    input  tmwf_pkg::sample_t sample,
    output logic              out_valid,
    input  logic              out_stall,
    output tmwf_pkg::chan_t   out_channel,
    output tmwf_pkg::sample_t filtered
);

    import tmwf_pkg::*;

    `include "trimmed_mean_window_filter_core_assert.svh"

    // trim lowered so that at least one value is averaged
    localparam int EFF_TRIM   = (2 * TRIM_COUNT >= WINDOW_DEPTH) ?
                                ((WINDOW_DEPTH - 1) / 2) : TRIM_COUNT;
    localparam int KEEP_COUNT = WINDOW_DEPTH - 2 * EFF_TRIM;
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_DEPTH);
    // reciprocal of the kept count, exact for every sum
    localparam int RECIP_S    = SUM_W + 4;
    localparam int RECIP_W    = RECIP_S + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_S) + KEEP_COUNT - 1) / KEEP_COUNT);
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int ROW_W      = WINDOW_DEPTH * SAMPLE_W;
    localparam int AW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_EXT_W   = (AW > CHAN_W) ? AW : CHAN_W;
    localparam int SW         = $clog2(WINDOW_DEPTH);
    localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW_DEPTH - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MERGE = 2'd1;
    localparam logic [1:0] ST_ACC   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SW-1:0]     write_slot_reg, write_slot_next;
    chan_t             chan_reg, chan_next;
    sample_t           sample_reg, sample_next;
    logic [PROD_W-1:0] product_reg, product_next;
    logic              out_valid_reg, out_valid_next;
    chan_t             out_channel_reg, out_channel_next;
    sample_t           filtered_reg, filtered_next;

    logic              in_accept;
    logic              out_busy;
    logic              in_range_now;
    logic              last_chan;
    logic [CH_EXT_W-1:0] rd_ch_ext;
    logic [CH_EXT_W-1:0] wr_ch_ext;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  merged_row;
    logic              mem_wr;
    logic              acc_start;
    logic [SUM_W-1:0]  acc_sum;
    acc_stat_t         acc_stat;

    assign in_accept    = in_valid && !in_stall;
    assign in_stall     = (state_reg != ST_IDLE);
    assign out_busy     = out_valid_reg && out_stall;
    assign in_range_now = (int'(channel) < CHANNELS);
    assign last_chan    = (int'(chan_reg) == CHANNELS - 1);
    assign rd_ch_ext    = CH_EXT_W'(channel);
    assign wr_ch_ext    = CH_EXT_W'(chan_reg);

    // new sample replaces the entry at the shared slot
    always_comb
    begin
        merged_row = rd_row;
        for (int s = 0; s < WINDOW_DEPTH; s++)
        begin
            if (SW'(s) == write_slot_reg)
            begin
                merged_row[s*SAMPLE_W +: SAMPLE_W] = sample_reg;
            end
        end
    end

    assign mem_wr    = (state_reg == ST_MERGE);
    assign acc_start = (state_reg == ST_MERGE);

    tmwf_row_mem #(
        .ROWS  (CHANNELS),
        .ROW_W (ROW_W),
        .AW    (AW)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (rd_ch_ext[AW-1:0]),
        .wr_en   (mem_wr),
        .wr_addr (wr_ch_ext[AW-1:0]),
        .wr_data (merged_row),
        .rd_data (rd_row)
    );

    tmwf_rank_acc #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TRIM         (EFF_TRIM),
        .SUM_W        (SUM_W)
    ) u_rank_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (acc_start),
        .window (merged_row),
        .sum    (acc_sum),
        .stat   (acc_stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        chan_next        = chan_reg;
        sample_next      = sample_reg;
        product_next     = product_reg;
        out_valid_next   = out_valid_reg;
        out_channel_next = out_channel_reg;
        filtered_next    = filtered_reg;

        // output register empties when collected
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    chan_next   = channel;
                    sample_next = sample;
                    if (in_range_now)
                    begin
                        state_next = ST_MERGE;
                    end
                    else
                    begin
                        // out-of-range channel: zero result, windows untouched
                        product_next = '0;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_MERGE:
            begin
                if (last_chan)
                begin
                    write_slot_next = (write_slot_reg == SLOT_LAST) ?
                                      '0 : write_slot_reg + SW'(1);
                end
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (acc_stat.done)
                begin
                    product_next = PROD_W'(acc_sum) * PROD_W'(RECIP);
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next   = 1'b1;
                    out_channel_next = chan_reg;
                    filtered_next    = product_reg[RECIP_S +: SAMPLE_W];
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg        <= chan_next;
        sample_reg      <= sample_next;
        product_reg     <= product_next;
        out_channel_reg <= out_channel_next;
        filtered_reg    <= filtered_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign filtered    = filtered_reg;

    `TMWF_ASSERT_SAME(a_slot_in_range, clk, rst_n, 1'b1, write_slot_reg <= SLOT_LAST,
        "write slot beyond window depth")
    `TMWF_ASSERT_SAME(a_slot_moves_on_merge, clk, rst_n, !$stable(write_slot_reg),
        $past(state_reg) == ST_MERGE, "write slot moved outside merge")
    `TMWF_ASSERT_SAME(a_done_in_acc, clk, rst_n, acc_stat.done, state_reg == ST_ACC,
        "rank unit finished outside accumulate state")
    `TMWF_ASSERT_SAME(a_idle_unit_quiet, clk, rst_n, state_reg == ST_IDLE,
        !acc_stat.busy, "rank unit busy while idle")
    `TMWF_ASSERT_NEXT(a_emit_loads, clk, rst_n, (state_reg == ST_EMIT) && !out_busy,
        out_valid_reg && (state_reg == ST_IDLE), "result not loaded from emit")

endmodule

/* sim/trimmed_mean_window_filter_core_test.sv */
`timescale 1ns / 100ps

module trimmed_mean_window_filter_core_test;

    import tmwf_pkg::*;

    // block sizes, kept the same as the defaults of the core
    localparam int N_CHAN    = 8;
    localparam int WIN_DEPTH = 6;
    localparam int TRIM      = 2;
    // trim is pulled in when it would leave nothing to average
    localparam int TRIM_EFF  = (2 * TRIM >= WIN_DEPTH) ? (WIN_DEPTH - 1) / 2 : TRIM;
    localparam int KEEP_CNT  = WIN_DEPTH - 2 * TRIM_EFF;

    // sample value mixes for the random scans
    typedef enum int {
        MIX_FULL,
        MIX_RAILS,
        MIX_LOW,
        MIX_CLUSTER,
        MIX_HIGH
    } sample_mix_e;

    typedef struct {
        chan_t   ch;
        sample_t val;
    } filt_result_t;

    typedef struct {
        chan_t   ch;
        sample_t smp;
        bit      typed;
        sample_t want;
    } dir_row_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_stall;
    chan_t   channel   = '0;
    sample_t sample    = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    chan_t   out_channel;
    sample_t filtered;

    // idling percentages for each side, changed between phases
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // long receiver hold-off, timed by its own process
    bit   hold_req = 1'b0;
    logic hold_on  = 1'b0;

    int unsigned err_count = 0;

    // filtered values still owed by the core, oldest first
    filt_result_t owed_results[$];

    // shadow copy of the channel windows and the shared slot
    sample_t     win_mem [N_CHAN][WIN_DEPTH];
    int unsigned slot_pos;

    // directed rows: after reset most of the window is still zero, so the first two
    // scans give zero whatever the samples are; later rows go to the predictor
    dir_row_t dir_rows [0:21] = '{
        // first scan, slot 0: rails and a spread of values
        '{3'd0, 12'd0,    1'b1, 12'd0},
        '{3'd1, 12'd4095, 1'b1, 12'd0},
        '{3'd2, 12'd1,    1'b1, 12'd0},
        '{3'd3, 12'd2048, 1'b1, 12'd0},
        '{3'd4, 12'd4094, 1'b1, 12'd0},
        '{3'd5, 12'd2730, 1'b1, 12'd0},
        '{3'd6, 12'd1365, 1'b1, 12'd0},
        '{3'd7, 12'd4095, 1'b1, 12'd0},
        // second scan, slot 1: full scale everywhere
        '{3'd0, 12'd4095, 1'b1, 12'd0},
        '{3'd1, 12'd4095, 1'b1, 12'd0},
        '{3'd2, 12'd4095, 1'b1, 12'd0},
        '{3'd3, 12'd4095, 1'b1, 12'd0},
        '{3'd4, 12'd4095, 1'b1, 12'd0},
        '{3'd5, 12'd4095, 1'b1, 12'd0},
        '{3'd6, 12'd4095, 1'b1, 12'd0},
        '{3'd7, 12'd4095, 1'b1, 12'd0},
        // out of order: the last channel twice in a row moves the slot twice
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd2, 12'd4095, 1'b0, 12'd0},
        '{3'd0, 12'd123,  1'b0, 12'd0},
        '{3'd5, 12'd4095, 1'b0, 12'd0},
        '{3'd6, 12'd0,    1'b0, 12'd0}
    };

    trimmed_mean_window_filter_core #(
        .CHANNELS     (N_CHAN),
        .WINDOW_DEPTH (WIN_DEPTH),
        .TRIM_COUNT   (TRIM)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .filtered    (filtered)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // writes one sample into the shadow windows and returns the trimmed mean
    function automatic sample_t trimmed_mean_update(input chan_t ch, input sample_t smp);
        sample_t     ranked [WIN_DEPTH];
        sample_t     hold_val;
        int unsigned acc;
        int          i;
        int          j;
        if (ch >= N_CHAN)
            return '0;
        if (slot_pos >= WIN_DEPTH)
            slot_pos = 0;
        win_mem[ch][slot_pos] = smp;
        for (i = 0; i < WIN_DEPTH; i++)
            ranked[i] = win_mem[ch][i];
        // insertion sort, ascending
        for (i = 1; i < WIN_DEPTH; i++)
        begin
            hold_val = ranked[i];
            j = i - 1;
            while (j >= 0 && ranked[j] > hold_val)
            begin
                ranked[j + 1] = ranked[j];
                j--;
            end
            ranked[j + 1] = hold_val;
        end
        acc = 0;
        for (i = TRIM_EFF; i < WIN_DEPTH - TRIM_EFF; i++)
            acc += ranked[i];
        // only the last channel of a scan moves the shared slot
        if (ch == N_CHAN - 1)
            slot_pos = (slot_pos + 1) % WIN_DEPTH;
        return sample_t'(acc / KEEP_CNT);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        err_count++;
    endtask

    // offers one item, honouring the idle rate, and books its result once taken
    task automatic send_sample(input chan_t ch, input sample_t smp,
                               input bit typed, input sample_t want);
        filt_result_t res;
        sample_t      model_val;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // keep the shadow state moving even where the value is typed in
        model_val = trimmed_mean_update(ch, smp);
        res.ch  = ch;
        res.val = typed ? want : model_val;
        owed_results.push_back(res);
    endtask

    // drops valid and waits for every owed result to come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic sample_t pick_sample(input sample_mix_e mix, input sample_t centre);
        int v;
        case (mix)
            MIX_RAILS:   return $urandom_range(1) ? 12'hFFF : 12'h000;
            MIX_LOW:     return sample_t'($urandom_range(15));
            MIX_HIGH:    return sample_t'($urandom_range(4095, 4080));
            MIX_CLUSTER:
            begin
                v = int'(centre) + int'($urandom_range(6)) - 3;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                return sample_t'(v);
            end
            default:     return sample_t'($urandom_range(4095));
        endcase
    endfunction

    // mostly whole scans in channel order, with stray out-of-order samples mixed in
    task automatic run_random_scans(input int n_items);
        int          sent;
        int          c;
        sample_mix_e mix;
        sample_t     centre;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                // stray sample on any channel
                send_sample(chan_t'($urandom_range(7)), sample_t'($urandom_range(4095)),
                            1'b0, '0);
                sent++;
            end
            else
            begin
                mix    = sample_mix_e'($urandom_range(4));
                centre = sample_t'($urandom_range(4095));
                for (c = 0; c < N_CHAN; c++)
                    send_sample(chan_t'(c), pick_sample(mix, centre), 1'b0, '0);
                sent += N_CHAN;
            end
        end
    endtask

    // receiver: drives the stall and checks every result it takes
    always @(posedge clk)
    begin
        filt_result_t owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
                report_mismatch($sformatf("result with nothing owed: channel %0d value %0d",
                                          out_channel, filtered));
            else
            begin
                owed = owed_results.pop_front();
                if (out_channel !== owed.ch)
                    report_mismatch($sformatf("out_channel %0d, wanted %0d",
                                              out_channel, owed.ch));
                if (filtered !== owed.val)
                    report_mismatch($sformatf("filtered %0d on channel %0d, wanted %0d",
                                              filtered, owed.ch, owed.val));
            end
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end

    // long hold-off, so the output register and the pipe fill and the input stalls
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int r;
        for (int c = 0; c < N_CHAN; c++)
            for (int d = 0; d < WIN_DEPTH; d++)
                win_mem[c][d] = '0;
        slot_pos = 0;

        // reset held low at the start, released on an edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, no idling
        for (r = 0; r < 22; r++)
            send_sample(dir_rows[r].ch, dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].want);
        wait_drained();

        // random phases: quiet, sender idling, receiver stalling, both
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random_scans(290);
        wait_drained();

        send_idle_pct = 46;
        recv_stall_pct = 0;
        run_random_scans(290);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 46;
        run_random_scans(290);
        wait_drained();

        send_idle_pct = 22;
        recv_stall_pct = 22;
        run_random_scans(290);
        wait_drained();

        // pressure: receiver holds off while the sender keeps offering items
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        run_random_scans(40);
        wait_drained();

        // settle time for anything stray from the core
        repeat (30) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tmwf_pkg.sv
hdl/tmwf_row_mem.sv
hdl/tmwf_rank_acc.sv
hdl/trimmed_mean_window_filter_core.sv
sim/trimmed_mean_window_filter_core_test.sv
